// ===== hw/rtl/rmcp_pkg.sv =====
// Shared types and constants of the RMC position sentence parser.
package rmcp_pkg;

  // Field number within the sentence, counted in commas from the start.
  // Every field past the date field is lumped together as FLD_TAIL.
  typedef enum logic [3:0] {
    FLD_HEAD   = 4'd0,
    FLD_TIME   = 4'd1,
    FLD_STATUS = 4'd2,
    FLD_LAT    = 4'd3,
    FLD_NS     = 4'd4,
    FLD_LON    = 4'd5,
    FLD_EW     = 4'd6,
    FLD_SPEED  = 4'd7,
    FLD_COURSE = 4'd8,
    FLD_DATE   = 4'd9,
    FLD_TAIL   = 4'd10
  } fld_t;

  // Result codes; a comma count error wins, else the first failure in field order.
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_COUNT    = 3'd1,
    ERR_TOO_LONG = 3'd2,
    ERR_STATUS   = 3'd3,
    ERR_NS       = 3'd4,
    ERR_EW       = 3'd5
  } err_t;

  // Character codes.
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_W     = 8'h57;

  // Number formats.
  localparam int          MIN_W     = 27;
  localparam logic [29:0] UTC_CAP   = 30'd999999999;
  localparam logic [29:0] MIN_CAP   = 30'd99999999;
  localparam logic [2:0]  TIME_FRAC = 3'd3;
  localparam logic [2:0]  MIN_FRAC  = 3'd6;
  localparam logic [3:0]  LAT_DEG_DIGITS = 4'd2;
  localparam logic [3:0]  LON_DEG_DIGITS = 4'd3;
  localparam logic [3:0]  LEN_MAX   = 4'd15;

  // Field length limits.
  localparam logic [3:0] LEN_TIME   = 4'd10;
  localparam logic [3:0] LEN_LETTER = 4'd1;
  localparam logic [3:0] LEN_LAT    = 4'd11;
  localparam logic [3:0] LEN_LON    = 4'd12;
  localparam logic [3:0] LEN_AUX    = 4'd6;

  // Result data bus width: 103 bits of fields padded to whole bytes.
  localparam int OUT_DATA_W = 104;

  // Snapshot of one finished field, handed from the scanner to the closer.
  typedef struct packed {
    fld_t        fld;
    logic        last;
    logic        cnt_ok;
    logic [3:0]  len;
    logic [29:0] num;
    logic [9:0]  deg;
    logic [2:0]  frac;
    logic [7:0]  head;
  } rmcp_rec_t;

endpackage

// ===== hw/rtl/rmc_position_sentence_parser.sv =====
// Top level of the RMC position sentence parser.
// This block takes an RMC position sentence one byte per request on the input
// stream, with in_tlast set on the final byte, and gives one result per
// sentence. Bytes are split at commas; the time, latitude and longitude fields
// are turned into fixed point (thousandths of a second, whole degrees and
// millionths of a minute, saturating at their limits) and the status,
// hemisphere and length rules are checked. A comma count error decides the error
// code, else the first failure in field order does. A sentence must hold exactly
// EXPECTED_COMMAS commas. Error results carry zero values. The block accepts one
// byte in every cycle but for the stall named below. A byte first updates the
// scanner's field registers; a comma or the last byte hands a snapshot of the
// closed field to the closer stage, which runs the field checks and the fraction
// scaling multiply. The output register takes the result when the closer takes
// the last byte's snapshot. Input stalls only when that snapshot waits on the
// closer while the previous result still sits untaken in the output register.
module rmc_position_sentence_parser #(
  parameter int EXPECTED_COMMAS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // char_byte
  input  logic         in_tlast,   // is_last
  output logic         out_tvalid,
  input  logic         out_tready,
  // utc_thousandths[29:0], lat_degrees[36:30], lat_minutes_micro[63:37],
  // is_north[64], lon_degrees[74:65], lon_minutes_micro[101:75], is_east[102],
  // zero pad[103]
  output logic [103:0] out_tdata,
  output logic [2:0]   out_tuser   // error_code
);
  import rmcp_pkg::*;

  rmcp_rec_t rec;
  logic      rec_valid;
  logic      rec_take;

  // Comma counting and per-field number accumulation.
  rmcp_scan #(
    .EXPECTED_COMMAS(EXPECTED_COMMAS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .rec_take  (rec_take),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  // Field checks, value storage and the result register.
  rmcp_close u_close (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (rec_valid),
    .rec_i      (rec),
    .rec_take   (rec_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hw/rtl/rmcp_scan.sv =====
// Byte scanner: counts commas and accumulates the numbers of the open field.
module rmcp_scan #(
  parameter int EXPECTED_COMMAS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                rec_take,
  output logic                rec_valid,
  output rmcp_pkg::rmcp_rec_t rec
);
  import rmcp_pkg::*;

  localparam int CW = $clog2(EXPECTED_COMMAS + 2);
  localparam logic [CW-1:0] CNT_TOP = CW'(EXPECTED_COMMAS + 1);
  localparam logic [CW-1:0] CNT_OK  = CW'(EXPECTED_COMMAS);

  function automatic logic [29:0] clamp_mul10(input logic [29:0] acc,
                                              input logic [3:0]  add,
                                              input logic [29:0] cap);
    logic [33:0] v;
    v = 34'(acc) * 34'd10 + 34'(add);
    return (v > 34'(cap)) ? cap : v[29:0];
  endfunction

  logic [CW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [3:0]    len_r, len_nxt;
  logic [29:0]   num_r, num_nxt;
  logic [9:0]    deg_r, deg_nxt;
  logic [2:0]    frac_r, frac_nxt;
  logic          point_r, point_nxt;
  logic          stop_r, stop_nxt;
  logic [7:0]    head_r, head_nxt;
  logic          rec_valid_r, rec_valid_nxt;
  rmcp_rec_t     rec_r, rec_nxt;

  fld_t        fld;
  logic        fire, is_comma, is_digit, is_point, is_angle;
  logic        in_deg, min_start, num_on, stop_eff;
  logic [3:0]  ndeg;
  logic [2:0]  fmax;
  logic [29:0] cap, num_mul;
  logic [3:0]  tk_len;
  logic [29:0] tk_num;
  logic [9:0]  tk_deg;
  logic [2:0]  tk_frac;
  logic        tk_point, tk_stop;
  logic [7:0]  tk_head;

  assign in_tready = !rec_valid_r || rec_take;
  assign fire      = in_tvalid && in_tready;
  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

  always_comb begin
    fld       = (cnt_r > CW'(FLD_TAIL)) ? FLD_TAIL : fld_t'(cnt_r[3:0]);
    is_comma  = (in_tdata == CH_COMMA);
    is_point  = (in_tdata == CH_POINT);
    is_digit  = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
    is_angle  = (fld == FLD_LAT) || (fld == FLD_LON);
    ndeg      = (fld == FLD_LAT) ? LAT_DEG_DIGITS : LON_DEG_DIGITS;
    in_deg    = is_angle && (len_r < ndeg);
    min_start = is_angle && (len_r == ndeg);
    num_on    = (fld == FLD_TIME) || (is_angle && !in_deg);
    fmax      = (fld == FLD_TIME) ? TIME_FRAC : MIN_FRAC;
    cap       = (fld == FLD_TIME) ? UTC_CAP : MIN_CAP;
    stop_eff  = min_start ? 1'b0 : stop_r;
    num_mul   = clamp_mul10(num_r, in_tdata[3:0], cap);
    cnt_inc   = (cnt_r == CNT_TOP) ? cnt_r : cnt_r + 1'b1;

    // Effect of taking one ordinary byte into the open field.
    tk_len   = (len_r == LEN_MAX) ? len_r : len_r + 4'd1;
    tk_head  = (len_r == 4'd0) ? in_tdata : head_r;
    tk_num   = num_r;
    tk_deg   = deg_r;
    tk_frac  = frac_r;
    tk_point = point_r;
    tk_stop  = stop_r;
    if (in_deg) begin
      if (!stop_r && is_digit) begin
        tk_deg = 10'(deg_r * 10'd10 + 10'(in_tdata[3:0]));
      end else begin
        tk_stop = 1'b1;
      end
    end else if (num_on) begin
      tk_stop = stop_eff;
      if (!stop_eff) begin
        if (is_digit) begin
          if (!point_r) begin
            tk_num = num_mul;
          end else if (frac_r < fmax) begin
            tk_num  = num_mul;
            tk_frac = frac_r + 3'd1;
          end
        end else if (is_point && !point_r) begin
          tk_point = 1'b1;
        end else begin
          tk_stop = 1'b1;
        end
      end
    end
  end

  // Snapshot of the field that a comma or the last byte closes.
  always_comb begin
    rec_nxt.fld    = fld;
    rec_nxt.last   = in_tlast;
    rec_nxt.cnt_ok = ((is_comma ? cnt_inc : cnt_r) == CNT_OK);
    if (is_comma) begin
      rec_nxt.len  = len_r;
      rec_nxt.num  = num_r;
      rec_nxt.deg  = deg_r;
      rec_nxt.frac = frac_r;
      rec_nxt.head = head_r;
    end else begin
      rec_nxt.len  = tk_len;
      rec_nxt.num  = tk_num;
      rec_nxt.deg  = tk_deg;
      rec_nxt.frac = tk_frac;
      rec_nxt.head = tk_head;
    end
    if (fire && (is_comma || in_tlast)) begin
      rec_valid_nxt = 1'b1;
    end else if (rec_take) begin
      rec_valid_nxt = 1'b0;
    end else begin
      rec_valid_nxt = rec_valid_r;
    end
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    num_nxt   = num_r;
    deg_nxt   = deg_r;
    frac_nxt  = frac_r;
    point_nxt = point_r;
    stop_nxt  = stop_r;
    head_nxt  = head_r;
    if (fire) begin
      if (is_comma || in_tlast) begin
        len_nxt   = 4'd0;
        num_nxt   = '0;
        deg_nxt   = '0;
        frac_nxt  = '0;
        point_nxt = 1'b0;
        stop_nxt  = 1'b0;
        head_nxt  = '0;
      end else begin
        len_nxt   = tk_len;
        num_nxt   = tk_num;
        deg_nxt   = tk_deg;
        frac_nxt  = tk_frac;
        point_nxt = tk_point;
        stop_nxt  = tk_stop;
        head_nxt  = tk_head;
      end
      if (in_tlast) begin
        cnt_nxt = '0;
      end else if (is_comma) begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      len_r       <= '0;
      num_r       <= '0;
      deg_r       <= '0;
      frac_r      <= '0;
      point_r     <= 1'b0;
      stop_r      <= 1'b0;
      head_r      <= '0;
      rec_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      num_r       <= num_nxt;
      deg_r       <= deg_nxt;
      frac_r      <= frac_nxt;
      point_r     <= point_nxt;
      stop_r      <= stop_nxt;
      head_r      <= head_nxt;
      rec_valid_r <= rec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (is_comma || in_tlast)) begin
      rec_r <= rec_nxt;
    end
  end

endmodule

// ===== hw/rtl/rmcp_close.sv =====
// Field closer: checks each finished field, keeps the parsed values, forms the result.
module rmcp_close (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  rec_valid,
  input  rmcp_pkg::rmcp_rec_t                   rec_i,
  output logic                                  rec_take,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [rmcp_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [2:0]                            out_tuser
);
  import rmcp_pkg::*;

  function automatic logic [19:0] pow10(input logic [2:0] k);
    logic [19:0] p;
    unique case (k)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      3'd6:    p = 20'd1000000;
      default: p = 20'd1;
    endcase
    return p;
  endfunction

  err_t        ferr_r, ferr_nxt;
  logic [29:0] utc_r, utc_nxt;
  logic [6:0]  lat_deg_r, lat_deg_nxt;
  logic [26:0] lat_min_r, lat_min_nxt;
  logic [9:0]  lon_deg_r, lon_deg_nxt;
  logic [26:0] lon_min_r, lon_min_nxt;
  logic        north_r, north_nxt;
  logic        east_r, east_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  err_t        out_code_r, code;

  logic        out_busy;
  logic [2:0]  fmax;
  logic [29:0] cap, scaled;
  logic [49:0] prod;
  err_t        err_new;

  assign out_busy   = out_valid_r && !out_tready;
  assign rec_take   = rec_valid && !(rec_i.last && out_busy);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_code_r;

  // Missing fraction digits are made up by one scaling multiply.
  always_comb begin
    fmax   = (rec_i.fld == FLD_TIME) ? TIME_FRAC : MIN_FRAC;
    cap    = (rec_i.fld == FLD_TIME) ? UTC_CAP : MIN_CAP;
    prod   = 50'(rec_i.num) * 50'(pow10(fmax - rec_i.frac));
    scaled = (prod > 50'(cap)) ? cap : prod[29:0];
  end

  always_comb begin
    err_new     = ERR_NONE;
    utc_nxt     = utc_r;
    lat_deg_nxt = lat_deg_r;
    lat_min_nxt = lat_min_r;
    lon_deg_nxt = lon_deg_r;
    lon_min_nxt = lon_min_r;
    north_nxt   = north_r;
    east_nxt    = east_r;
    if (rec_take && (ferr_r == ERR_NONE)) begin
      unique case (rec_i.fld) inside
        FLD_TIME: begin
          if (rec_i.len > LEN_TIME) err_new = ERR_TOO_LONG;
          else utc_nxt = scaled;
        end
        FLD_STATUS: begin
          if (rec_i.len > LEN_LETTER) err_new = ERR_TOO_LONG;
          else if (rec_i.head != CH_A) err_new = ERR_STATUS;
        end
        FLD_LAT: begin
          if (rec_i.len > LEN_LAT) begin
            err_new = ERR_TOO_LONG;
          end else begin
            lat_deg_nxt = rec_i.deg[6:0];
            lat_min_nxt = scaled[MIN_W-1:0];
          end
        end
        FLD_NS: begin
          if (rec_i.len > LEN_LETTER) err_new = ERR_TOO_LONG;
          else if (rec_i.head == CH_N) north_nxt = 1'b1;
          else if (rec_i.head == CH_S) north_nxt = 1'b0;
          else err_new = ERR_NS;
        end
        FLD_LON: begin
          if (rec_i.len > LEN_LON) begin
            err_new = ERR_TOO_LONG;
          end else begin
            lon_deg_nxt = rec_i.deg;
            lon_min_nxt = scaled[MIN_W-1:0];
          end
        end
        FLD_EW: begin
          if (rec_i.len > LEN_LETTER) err_new = ERR_TOO_LONG;
          else if (rec_i.head == CH_E) east_nxt = 1'b1;
          else if (rec_i.head == CH_W) east_nxt = 1'b0;
          else err_new = ERR_EW;
        end
        FLD_SPEED, FLD_COURSE, FLD_DATE: begin
          if (rec_i.len > LEN_AUX) err_new = ERR_TOO_LONG;
        end
        default: begin
        end
      endcase
    end
    ferr_nxt = (ferr_r == ERR_NONE) ? err_new : ferr_r;
  end

  // Result word; an error result carries zero values.
  always_comb begin
    code = rec_i.cnt_ok ? ferr_nxt : ERR_COUNT;
    if (code == ERR_NONE) begin
      out_data_nxt = {1'b0, east_nxt, lon_min_nxt, lon_deg_nxt, north_nxt,
                      lat_min_nxt, lat_deg_nxt, utc_nxt};
    end else begin
      out_data_nxt = '0;
    end
    if (rec_take && rec_i.last) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ferr_r      <= ERR_NONE;
      utc_r       <= '0;
      lat_deg_r   <= '0;
      lat_min_r   <= '0;
      lon_deg_r   <= '0;
      lon_min_r   <= '0;
      north_r     <= 1'b0;
      east_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (rec_take && rec_i.last) begin
        ferr_r    <= ERR_NONE;
        utc_r     <= '0;
        lat_deg_r <= '0;
        lat_min_r <= '0;
        lon_deg_r <= '0;
        lon_min_r <= '0;
        north_r   <= 1'b0;
        east_r    <= 1'b0;
      end else begin
        ferr_r    <= ferr_nxt;
        utc_r     <= utc_nxt;
        lat_deg_r <= lat_deg_nxt;
        lat_min_r <= lat_min_nxt;
        lon_deg_r <= lon_deg_nxt;
        lon_min_r <= lon_min_nxt;
        north_r   <= north_nxt;
        east_r    <= east_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take && rec_i.last) begin
      out_data_r <= out_data_nxt;
      out_code_r <= code;
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_code_r != ERR_NONE)) |-> (out_data_r == '0))
    else $error("error result carries nonzero values");

  a_utc_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[29:0] <= UTC_CAP))
    else $error("time value above its saturation limit");

  a_min_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((30'(out_data_r[63:37]) <= MIN_CAP) &&
                     (30'(out_data_r[101:75]) <= MIN_CAP) &&
                     (out_data_r[36:30] <= 7'd99)))
    else $error("position value out of range");

  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_take && rec_i.last) |=> out_valid_r)
    else $error("last byte of a sentence gave no result");
`endif

endmodule
